FILE: src/chacha_pkg.sv
package chacha_pkg;

    localparam int unsigned NumCfg = 7;
    localparam logic [2:0] CfgKey01   = 3'd0;
    localparam logic [2:0] CfgKey23   = 3'd1;
    localparam logic [2:0] CfgKey45   = 3'd2;
    localparam logic [2:0] CfgKey67   = 3'd3;
    localparam logic [2:0] CfgNonceLo = 3'd4;
    localparam logic [2:0] CfgNonceHi = 3'd5;
    localparam logic [2:0] CfgCounter = 3'd6;

    localparam logic [31:0] Sigma0 = 32'h61707865;
    localparam logic [31:0] Sigma1 = 32'h3320646e;
    localparam logic [31:0] Sigma2 = 32'h79622d32;
    localparam logic [31:0] Sigma3 = 32'h6b206574;

    // queue of input words between front and back
    localparam int unsigned QDepth = 4;

    typedef logic [31:0] t_word;
    typedef t_word [15:0] t_state;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_quad;

    function automatic t_word rotl(input t_word v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic t_quad qround(input t_quad q);
        t_quad r;
        r = q;
        r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 16);
        r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 12);
        r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 8);
        r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 7);
        return r;
    endfunction

endpackage

FILE: src/chacha20_stream_cipher_core.sv
// ChaCha20 byte cipher: each pushed word (a byte and a last flag) comes back
// XORed with the keystream. Bytes pass through a 4-entry input queue, taken
// while no block is computed and the output is free. Before the first byte of
// each 64-byte block or message, the block function runs on one shared
// quarter-round array, a half round per cycle, then the feed-forward add. The
// user must write configuration only while idle; the block does not enforce
// it. Writing the counter register reloads the block counter at once.
module chacha20_stream_cipher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_input_byte,
    input  logic        i_last_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_output_byte,
    output logic        o_last_out
);
    chacha_pkg::t_item w_in, w_q_item;
    logic w_q_empty, w_q_pop;

    assign w_in.data = i_input_byte;
    assign w_in.last = i_last_of_message;

    chacha_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_item(w_in), .o_full(full),
        .i_pop(w_q_pop), .o_empty(w_q_empty), .o_item(w_q_item)
    );

    chacha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_q_empty(w_q_empty), .i_q_item(w_q_item), .o_q_pop(w_q_pop),
        .o_empty(empty), .i_pop(pop),
        .o_output_byte(o_output_byte), .o_last_out(o_last_out)
    );
endmodule

FILE: src/chacha_fifo.sv
module chacha_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  chacha_pkg::t_item  i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output chacha_pkg::t_item  o_item
);
    localparam int unsigned Aw = $clog2(chacha_pkg::QDepth);

    chacha_pkg::t_item r_mem [chacha_pkg::QDepth];
    logic [Aw-1:0] r_wr, r_rd;
    logic [Aw:0]   r_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == (Aw+1)'(chacha_pkg::QDepth));
    assign o_empty = (r_cnt == '0);
    assign w_wr = i_push && !o_full;
    assign w_rd = i_pop && !o_empty;
    assign o_item = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wr <= r_wr + 1'b1;
            if (w_rd) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (Aw+1)'(w_wr) - (Aw+1)'(w_rd);
        end
    end
endmodule

FILE: src/chacha_core.sv
module chacha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_q_empty,
    input  chacha_pkg::t_item  i_q_item,
    output logic               o_q_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [7:0]         o_output_byte,
    output logic               o_last_out
);
    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StRound = 2'd1;
    localparam logic [1:0] StAdd = 2'd2;

    logic [63:0] r_key01, r_key23, r_key45, r_key67, r_nonce_lo;
    logic [31:0] r_nonce_hi, r_counter;
    chacha_pkg::t_state r_init, r_work, r_ks, w_init;
    logic [1:0]  r_st;
    logic [4:0]  r_rnd;
    logic [5:0]  r_pos;
    logic        r_ready;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic        w_out_free, w_take;
    logic [7:0]  w_ks;
    chacha_pkg::t_quad w_q [4];
    chacha_pkg::t_quad w_r [4];
    chacha_pkg::t_state w_next;

    always_comb begin
        w_init[0] = chacha_pkg::Sigma0;
        w_init[1] = chacha_pkg::Sigma1;
        w_init[2] = chacha_pkg::Sigma2;
        w_init[3] = chacha_pkg::Sigma3;
        w_init[4] = r_key01[31:0];  w_init[5] = r_key01[63:32];
        w_init[6] = r_key23[31:0];  w_init[7] = r_key23[63:32];
        w_init[8] = r_key45[31:0];  w_init[9] = r_key45[63:32];
        w_init[10] = r_key67[31:0]; w_init[11] = r_key67[63:32];
        w_init[12] = r_counter;
        w_init[13] = r_nonce_lo[31:0];
        w_init[14] = r_nonce_lo[63:32];
        w_init[15] = r_nonce_hi;
    end

    // even step: columns, odd step: diagonals; one half round a cycle
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (!r_rnd[0]) begin
                w_q[i] = '{r_work[i], r_work[4+i], r_work[8+i], r_work[12+i]};
            end else begin
                w_q[i] = '{r_work[i], r_work[4+((i+1)%4)],
                           r_work[8+((i+2)%4)], r_work[12+((i+3)%4)]};
            end
            w_r[i] = chacha_pkg::qround(w_q[i]);
        end
        w_next = r_work;
        for (int i = 0; i < 4; i++) begin
            w_next[i] = w_r[i].a;
            if (!r_rnd[0]) begin
                w_next[4+i] = w_r[i].b;
                w_next[8+i] = w_r[i].c;
                w_next[12+i] = w_r[i].d;
            end else begin
                w_next[4+((i+1)%4)] = w_r[i].b;
                w_next[8+((i+2)%4)] = w_r[i].c;
                w_next[12+((i+3)%4)] = w_r[i].d;
            end
        end
    end

    assign w_out_free = !r_ovalid || i_pop;
    assign w_take = (r_st == StIdle) && r_ready && !i_q_empty && w_out_free;
    assign o_q_pop = w_take;
    assign w_ks = r_ks[r_pos[5:2]][8*r_pos[1:0] +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key01 <= '0; r_key23 <= '0; r_key45 <= '0; r_key67 <= '0;
            r_nonce_lo <= '0; r_nonce_hi <= '0; r_counter <= '0;
            r_st <= StIdle;
            r_rnd <= '0;
            r_pos <= '0;
            r_ready <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_take) r_ovalid <= 1'b1;
            else if (i_pop) r_ovalid <= 1'b0;
            case (r_st)
                StIdle: begin
                    if (!r_ready && !i_q_empty) begin
                        r_init <= w_init;
                        r_work <= w_init;
                        r_rnd <= '0;
                        r_counter <= r_counter + 32'd1;
                        r_st <= StRound;
                    end else if (w_take) begin
                        r_obyte <= i_q_item.data ^ w_ks;
                        r_olast <= i_q_item.last;
                        if (i_q_item.last || r_pos == 6'd63) begin
                            r_pos <= '0;
                            r_ready <= 1'b0;
                        end else begin
                            r_pos <= r_pos + 6'd1;
                        end
                    end
                end
                StRound: begin
                    r_work <= w_next;
                    r_rnd <= r_rnd + 5'd1;
                    if (r_rnd == 5'd19) r_st <= StAdd;
                end
                StAdd: begin
                    for (int i = 0; i < 16; i++) r_ks[i] <= r_work[i] + r_init[i];
                    r_ready <= 1'b1;
                    r_pos <= '0;
                    r_st <= StIdle;
                end
                default: r_st <= StIdle;
            endcase
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    chacha_pkg::CfgKey01:   r_key01 <= i_cfg_data;
                    chacha_pkg::CfgKey23:   r_key23 <= i_cfg_data;
                    chacha_pkg::CfgKey45:   r_key45 <= i_cfg_data;
                    chacha_pkg::CfgKey67:   r_key67 <= i_cfg_data;
                    chacha_pkg::CfgNonceLo: r_nonce_lo <= i_cfg_data;
                    chacha_pkg::CfgNonceHi: r_nonce_hi <= i_cfg_data[31:0];
                    chacha_pkg::CfgCounter: r_counter <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_empty = !r_ovalid;
    assign o_output_byte = r_obyte;
    assign o_last_out = r_olast;
endmodule
